@@ hdl/rig_pkg.sv @@
// ----------------------------------------------------------------------------
// rig_pkg
// Shared constants for the radical inverse generator.
// ----------------------------------------------------------------------------
package rig_pkg;

  localparam int BASE_BITS  = 8;   // width of the radix field
  localparam int OUT_BITS   = 32;  // width of the fraction field
  localparam int DIGIT_STEP = 8;   // quotient bits resolved per division stage

endpackage

@@ hdl/rig_if.sv @@
// ----------------------------------------------------------------------------
// rig_sample_if / rig_result_if
// Valid/ready channels carrying samples in and fractions out.
// ----------------------------------------------------------------------------
interface rig_sample_if #(
  parameter int INDEX_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic [INDEX_BITS-1:0]         index;
  logic [rig_pkg::BASE_BITS-1:0] base;

  modport source (output valid, index, base, input ready);
  modport sink   (input valid, index, base, output ready);
endinterface

interface rig_result_if;
  logic                         valid;
  logic                         ready;
  logic [rig_pkg::OUT_BITS-1:0] fraction;

  modport source (output valid, fraction, input ready);
  modport sink   (input valid, fraction, output ready);
endinterface

@@ hdl/radical_inverse_generator.sv @@
// ----------------------------------------------------------------------------
// radical_inverse_generator
// Halton radical inverse of a sample index in a given base, unsigned Q0.FRAC.
// ----------------------------------------------------------------------------
// Usage:
//   sample : index and base in; one transfer per clock when ready is high.
//   result : fraction out, floor(R * 2^FRAC_BITS / b^k), low 32 bits.
//   Bases 0 and 1 and index 0 give a zero fraction.
// Timing:
//   One sample enters every cycle while the pipeline is not stalled; each
//   digit takes ceil(INDEX_BITS/8) restoring-division stages plus one
//   accumulate stage, and the final quotient takes one stage per fraction bit.
// Reset:
//   rst clears all stage valid bits; data registers are not reset.
// Stall:
//   While a result waits untaken the whole pipeline holds; nothing is lost
//   or repeated, and sample.ready is low while it waits.
// ----------------------------------------------------------------------------
module radical_inverse_generator #(
  parameter int INDEX_BITS = 24,
  parameter int FRAC_BITS  = 32
) (
  input  logic          clk,
  input  logic          rst,
  rig_sample_if.sink    sample,
  rig_result_if.source  result
);

  localparam int BB = rig_pkg::BASE_BITS;
  localparam int SUB = (INDEX_BITS + rig_pkg::DIGIT_STEP - 1) / rig_pkg::DIGIT_STEP;
  localparam int DS  = SUB + 1;
  localparam int ND  = INDEX_BITS * DS;
  localparam int NS  = ND + FRAC_BITS;
  localparam int W   = INDEX_BITS + BB;

  logic                  v      [NS];
  logic [INDEX_BITS-1:0] n_q    [NS];
  logic [INDEX_BITS-1:0] nw_q   [NS];
  logic [INDEX_BITS-1:0] dq_q   [NS];
  logic [BB-1:0]         b_q    [NS];
  logic [BB-1:0]         r_q    [NS];
  logic [W-1:0]          rev_q  [NS];
  logic [W-1:0]          den_q  [NS];
  logic [W-1:0]          rem_q  [NS];
  logic [FRAC_BITS-1:0]  quo_q  [NS];

  logic advance;

  assign advance       = !v[NS-1] || result.ready;
  assign sample.ready  = advance;
  assign result.valid  = v[NS-1];
  assign result.fraction = rig_pkg::OUT_BITS'(quo_q[NS-1]);

  genvar gi;
  generate
    for (gi = 0; gi < NS; gi++) begin : g_stage
      logic                  pv;
      logic [INDEX_BITS-1:0] pn, pnw, pdq;
      logic [BB-1:0]         pb, pr;
      logic [W-1:0]          prev, pden, prem;
      logic [FRAC_BITS-1:0]  pquo;

      logic [INDEX_BITS-1:0] n_next, nw_next, dq_next;
      logic [BB-1:0]         r_next;
      logic [W-1:0]          rev_next, den_next, rem_next;
      logic [FRAC_BITS-1:0]  quo_next;

      if (gi == 0) begin : g_src
        logic low_base;
        assign low_base = sample.base < BB'(2);
        assign pv   = sample.valid;
        assign pn   = low_base ? '0 : sample.index;
        assign pnw  = low_base ? '0 : sample.index;
        assign pdq  = '0;
        assign pb   = sample.base;
        assign pr   = '0;
        assign prev = '0;
        assign pden = W'(1);
        assign prem = '0;
        assign pquo = '0;
      end else begin : g_prev
        assign pv   = v[gi-1];
        assign pn   = n_q[gi-1];
        assign pnw  = nw_q[gi-1];
        assign pdq  = dq_q[gi-1];
        assign pb   = b_q[gi-1];
        assign pr   = r_q[gi-1];
        assign prev = rev_q[gi-1];
        assign pden = den_q[gi-1];
        assign prem = rem_q[gi-1];
        assign pquo = quo_q[gi-1];
      end

      if (gi < ND && (gi % DS) < SUB) begin : g_div
        localparam int S0 = (gi % DS) * rig_pkg::DIGIT_STEP;
        always_comb begin
          logic [BB:0] t;
          logic        qb;
          nw_next  = pnw;
          r_next   = pr;
          dq_next  = pdq;
          t        = '0;
          qb       = 1'b0;
          for (int k = 0; k < rig_pkg::DIGIT_STEP; k++) begin
            if (S0 + k < INDEX_BITS) begin
              t       = {r_next, nw_next[INDEX_BITS-1]};
              nw_next = nw_next << 1;
              qb      = t >= {1'b0, pb};
              r_next  = qb ? BB'(t - {1'b0, pb}) : t[BB-1:0];
              dq_next = {dq_next[INDEX_BITS-2:0], qb};
            end
          end
          n_next   = pn;
          rev_next = prev;
          den_next = pden;
          rem_next = prem;
          quo_next = pquo;
        end
      end else if (gi < ND) begin : g_acc
        always_comb begin
          logic [W+BB-1:0] pr_rev, pr_den;
          pr_rev   = prev * pb;
          pr_den   = pden * pb;
          if (pn != '0) begin
            rev_next = W'(pr_rev) + W'(pr);
            den_next = W'(pr_den);
            n_next   = pdq;
          end else begin
            rev_next = prev;
            den_next = pden;
            n_next   = pn;
          end
          nw_next  = n_next;
          dq_next  = '0;
          r_next   = '0;
          rem_next = prem;
          quo_next = pquo;
        end
      end else begin : g_quo
        always_comb begin
          logic [W:0] t;
          logic       qb;
          t        = (gi == ND) ? {prev, 1'b0} : {prem, 1'b0};
          qb       = t >= {1'b0, pden};
          rem_next = qb ? W'(t - {1'b0, pden}) : t[W-1:0];
          quo_next = {pquo[FRAC_BITS-2:0], qb};
          n_next   = pn;
          nw_next  = pnw;
          dq_next  = pdq;
          r_next   = pr;
          rev_next = prev;
          den_next = pden;
        end
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          v[gi] <= 1'b0;
        end else if (advance) begin
          v[gi] <= pv;
        end
      end

      always_ff @(posedge clk) begin
        if (advance) begin
          n_q[gi]   <= n_next;
          nw_q[gi]  <= nw_next;
          dq_q[gi]  <= dq_next;
          b_q[gi]   <= pb;
          r_q[gi]   <= r_next;
          rev_q[gi] <= rev_next;
          den_q[gi] <= den_next;
          rem_q[gi] <= rem_next;
          quo_q[gi] <= quo_next;
        end
      end
    end
  endgenerate

  a_ready_follows_output: assert property (@(posedge clk) disable iff (rst)
    sample.ready == (!result.valid || result.ready))
    else $error("sample.ready does not follow output stall");

  a_low_base_zero_index: assert property (@(posedge clk) disable iff (rst)
    v[0] && (b_q[0] < BB'(2)) |-> n_q[0] == '0)
    else $error("base below two entered with nonzero index");

  a_digit_below_base: assert property (@(posedge clk) disable iff (rst)
    v[SUB-1] && (b_q[SUB-1] >= BB'(2)) |-> r_q[SUB-1] < b_q[SUB-1])
    else $error("digit remainder not below base");

  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    v[NS-1] |-> rem_q[NS-1] < den_q[NS-1])
    else $error("quotient remainder not below denominator");

endmodule
